/* design/boxblur_pkg.sv */
// Shared types and constants for the 3x3 border-normalised box blur.
`default_nettype none

package boxblur_pkg;

	// Default sizes, handed to the top level's parameters
	localparam int MAX_WIDTH_DEF    = 1024;
	localparam int CHANNEL_BITS_DEF = 16;

	// Register reset values
	localparam logic [10:0] LINE_WIDTH_RST = 11'd640;
	localparam logic [15:0] FRAME_ROWS_RST = 16'd480;

	// Register select, taken from paddr[2]
	localparam logic REG_LINE_WIDTH = 1'b0;
	localparam logic REG_FRAME_ROWS = 1'b1;

	// Item kinds
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	// Odd factor of the divisor 2n once the power of two is shifted out
	typedef enum logic [1:0] {
		DIV_1,
		DIV_3,
		DIV_9
	} div_t;

	// Input word
	typedef struct packed {
		logic        kind;
		logic [15:0] chan_a_in;
		logic [15:0] chan_b_in;
		logic [15:0] chan_c_in;
	} pix_in_t;

	// Output word
	typedef struct packed {
		logic [15:0] chan_a_out;
		logic [15:0] chan_b_out;
		logic [15:0] chan_c_out;
		logic        frame_end;
	} pix_out_t;

endpackage

`default_nettype wire

/* design/box_blur_3x3_border_normalized.sv */
// 3x3 box blur over a three-channel raster stream, means normalised at the frame border.
//
// Use: pixel words (kind = pixel) enter on pix in raster order, one frame of
// line_width x frame_rows. After the last pixel, send line_width + 1 drain words
// (kind = drain) to flush the pending outputs. The blurred pixel for input p
// leaves with the word that enters line_width + 1 words later; frame_end marks
// the last pixel of the frame. Words that give no result just update state.
// Throughput: one word per clock while blur_stall does not hold the pipeline. The
// single line memory holds both previous rows per column and is read, then
// rewritten from the stage 1 registers; a write to the entry being read in the
// same cycle is forwarded. A result reaches blur through the window, sum,
// reciprocal multiply and correction stages; the memory read is issued at the
// edge that accepts the word causing it.
// Stall: blur_stall with a result waiting freezes the whole pipeline, and pix_stall
// follows in the same cycle. The user is to write registers over the APB-style port
// between frames; the block does not enforce it. pready is always high.
// Reset: counters clear and registers return to 640 x 480. The line memory is
// not cleared: entries not yet written belong to rows outside the frame and
// are masked out of every sum.
`default_nettype none

module box_blur_3x3_border_normalized
	import boxblur_pkg::*;
#(
	parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
	parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// pixel words in
	input  wire logic        pix_valid,
	output logic             pix_stall,
	input  wire pix_in_t     pix,
	// blurred words out
	output logic             blur_valid,
	input  wire logic        blur_stall,
	output pix_out_t         blur,
	// register port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int CNT_W = $clog2(MAX_WIDTH + 2);
	localparam int CB    = CHANNEL_BITS;
	localparam int PW    = 3 * CB;
	localparam int MW    = 2 * PW;
	localparam int SW    = CB + 4;
	localparam int NW    = CB + 5;
	localparam int XW    = CB + 4;
	localparam logic [XW-1:0] RECIP3 = XW'((64'd1 << XW) / 64'd3);
	localparam logic [XW-1:0] RECIP9 = XW'((64'd1 << XW) / 64'd9);

	// ---------------------------------------------------------------
	// Register port
	// ---------------------------------------------------------------
	logic [10:0] line_width_q;
	logic [15:0] frame_rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RST;
			frame_rows_q <= FRAME_ROWS_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_LINE_WIDTH: line_width_q <= pwdata[10:0];
				REG_FRAME_ROWS: frame_rows_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_LINE_WIDTH: prdata = 32'(line_width_q);
			REG_FRAME_ROWS: prdata = 32'(frame_rows_q);
			default:        prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	// Effective frame size: zero reads as one, width clipped to the memory
	logic [31:0]      lw_ext;
	logic [CNT_W-1:0] eff_w;
	logic [15:0]      eff_h;

	assign lw_ext = 32'(line_width_q);
	assign eff_w  = (lw_ext == 32'd0) ? CNT_W'(1) :
			(lw_ext > 32'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH) : CNT_W'(lw_ext);
	assign eff_h  = (frame_rows_q == 16'd0) ? 16'd1 : frame_rows_q;

	// ---------------------------------------------------------------
	// Flow control: one enable for the whole pipeline
	// ---------------------------------------------------------------
	logic adv;
	logic accept;
	logic blur_valid_q;

	assign adv       = !(blur_valid_q && blur_stall);
	assign pix_stall = !adv;
	assign accept    = pix_valid && adv;

	// ---------------------------------------------------------------
	// Input stage: frame counters and decisions
	// ---------------------------------------------------------------
	logic [COL_W-1:0] col_q, col_d, ocol_q, ocol_d;
	logic [15:0]      row_q, row_d, orow_q, orow_d;
	logic [CNT_W-1:0] pend_q, pend_d, fill_q, fill_d;

	logic             is_drain;
	logic             frame_open;
	logic             do_push;
	logic             do_restart;
	logic             fill_full;
	logic             do_emit;
	logic [COL_W-1:0] col_sel;
	logic [CNT_W-1:0] col_inc;
	logic             col_wrap;
	logic [CNT_W-1:0] ocol_inc;
	logic [16:0]      orow_inc;
	logic [2:0]       cmask;
	logic [2:0]       rmask;
	logic             last;
	logic [PW-1:0]    px;

	assign is_drain   = (pix.kind == KIND_DRAIN);
	assign frame_open = row_q < eff_h;
	assign do_push    = accept && (is_drain ? (!frame_open && pend_q != '0) : frame_open);
	assign do_restart = accept && is_drain && !frame_open && pend_q == '0;
	assign fill_full  = fill_q >= (eff_w + CNT_W'(1));
	assign do_emit    = do_push && fill_full;

	// column position of this push, wrapping at the row end
	assign col_sel  = (CNT_W'(col_q) >= eff_w) ? '0 : col_q;
	assign col_inc  = CNT_W'(col_sel) + CNT_W'(1);
	assign col_wrap = col_inc >= eff_w;

	// neighbour masks around the next output position (bit 0 = left / top)
	assign ocol_inc = CNT_W'(ocol_q) + CNT_W'(1);
	assign orow_inc = {1'b0, orow_q} + 17'd1;
	assign cmask    = {ocol_inc < eff_w, 1'b1, ocol_q != '0};
	assign rmask    = {orow_inc < {1'b0, eff_h}, 1'b1, orow_q != '0};
	assign last     = (orow_inc >= {1'b0, eff_h}) && (ocol_inc >= eff_w);

	assign px = is_drain ? '0 :
			{CB'(pix.chan_c_in), CB'(pix.chan_b_in), CB'(pix.chan_a_in)};

	always_comb begin
		col_d  = col_q;
		row_d  = row_q;
		pend_d = pend_q;
		fill_d = fill_q;
		ocol_d = ocol_q;
		orow_d = orow_q;
		if (do_restart) begin
			col_d  = '0;
			row_d  = '0;
			pend_d = '0;
			fill_d = '0;
			ocol_d = '0;
			orow_d = '0;
		end else if (do_push) begin
			col_d = col_wrap ? '0 : col_inc[COL_W-1:0];
			if (!is_drain && col_wrap) begin
				row_d = row_q + 16'd1;
			end
			if (!fill_full) begin
				fill_d = fill_q + CNT_W'(1);
			end
			if (!is_drain && !fill_full) begin
				pend_d = pend_q + CNT_W'(1);
			end
			if (is_drain && fill_full) begin
				pend_d = pend_q - CNT_W'(1);
			end
			if (fill_full) begin
				if (last) begin
					// frame done: start over
					col_d  = '0;
					row_d  = '0;
					pend_d = '0;
					fill_d = '0;
					ocol_d = '0;
					orow_d = '0;
				end else if (ocol_inc >= eff_w) begin
					ocol_d = '0;
					orow_d = orow_inc[15:0];
				end else begin
					ocol_d = ocol_inc[COL_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= '0;
			fill_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else begin
			col_q  <= col_d;
			row_q  <= row_d;
			pend_q <= pend_d;
			fill_q <= fill_d;
			ocol_q <= ocol_d;
			orow_q <= orow_d;
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: line memory read data, forwarding, write-back
	// ---------------------------------------------------------------
	logic             vld_s1, emit_s1;
	logic [PW-1:0]    px_s1;
	logic [COL_W-1:0] addr_s1;
	logic [2:0]       cm_s1, rm_s1;
	logic             last_s1;
	logic             fwd_s1;
	logic [MW-1:0]    fwd_dat_s1;
	logic [MW-1:0]    rd_q;
	logic [MW-1:0]    ent_cur;
	logic [PW-1:0]    older_cur, newer_cur;

	// entry holds {row before last, last row} for one column
	logic [MW-1:0] line_mem [MAX_WIDTH];

	assign ent_cur   = fwd_s1 ? fwd_dat_s1 : rd_q;
	assign older_cur = ent_cur[MW-1:PW];
	assign newer_cur = ent_cur[PW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			emit_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1  <= do_push;
			emit_s1 <= do_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1      <= px;
			addr_s1    <= col_sel;
			cm_s1      <= cmask;
			rm_s1      <= rmask;
			last_s1    <= last;
			// the entry read now is being rewritten at this same edge
			fwd_s1     <= vld_s1 && (addr_s1 == col_sel);
			fwd_dat_s1 <= {newer_cur, px_s1};
		end
	end

	// read-modify-write of the line memory
	always_ff @(posedge clk) begin
		if (adv) begin
			if (vld_s1) begin
				line_mem[addr_s1] <= {newer_cur, px_s1};
			end
			rd_q <= line_mem[col_sel];
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: window shift, divisor selection
	// ---------------------------------------------------------------
	logic [PW-1:0] win_q [3][3];
	logic          emit_s2, last_s2;
	logic [2:0]    cm_s2, rm_s2;
	logic [3:0]    n_s2;
	logic [1:0]    sh_s2;
	div_t          div_s2;
	logic [1:0]    ccnt, rcnt;
	logic [3:0]    n_c;
	logic [1:0]    sh_c;
	div_t          div_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < 3; s++) begin
				for (int r = 0; r < 3; r++) begin
					win_q[s][r] <= '0;
				end
			end
		end else if (adv && vld_s1) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2][0] <= older_cur;
			win_q[2][1] <= newer_cur;
			win_q[2][2] <= px_s1;
		end
	end

	// neighbour count n and the split of 2n into shift and odd factor
	assign ccnt = {1'b0, cm_s1[0]} + {1'b0, cm_s1[1]} + {1'b0, cm_s1[2]};
	assign rcnt = {1'b0, rm_s1[0]} + {1'b0, rm_s1[1]} + {1'b0, rm_s1[2]};
	assign n_c  = 4'(ccnt) * 4'(rcnt);

	always_comb begin
		case (n_c)
			4'd2:    begin sh_c = 2'd2; div_c = DIV_1; end
			4'd3:    begin sh_c = 2'd1; div_c = DIV_3; end
			4'd4:    begin sh_c = 2'd3; div_c = DIV_1; end
			4'd6:    begin sh_c = 2'd2; div_c = DIV_3; end
			4'd9:    begin sh_c = 2'd1; div_c = DIV_9; end
			default: begin sh_c = 2'd1; div_c = DIV_1; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s2 <= 1'b0;
		end else if (adv) begin
			emit_s2 <= emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cm_s2   <= cm_s1;
			rm_s2   <= rm_s1;
			n_s2    <= n_c;
			sh_s2   <= sh_c;
			div_s2  <= div_c;
			last_s2 <= last_s1;
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: masked sums over the window
	// ---------------------------------------------------------------
	logic [SW-1:0] sum_c  [3];
	logic [SW-1:0] sum_s3 [3];
	logic          emit_s3, last_s3;
	logic [3:0]    n_s3;
	logic [1:0]    sh_s3;
	div_t          div_s3;

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			sum_c[ch] = '0;
			for (int s = 0; s < 3; s++) begin
				for (int r = 0; r < 3; r++) begin
					if (cm_s2[s] && rm_s2[r]) begin
						sum_c[ch] = sum_c[ch] + SW'(win_q[s][r][ch*CB +: CB]);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s3 <= 1'b0;
		end else if (adv) begin
			emit_s3 <= emit_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3  <= sum_c;
			n_s3    <= n_s2;
			sh_s3   <= sh_s2;
			div_s3  <= div_s2;
			last_s3 <= last_s2;
		end
	end

	// ---------------------------------------------------------------
	// Stage 4: rounding offset, shift, reciprocal multiply
	// ---------------------------------------------------------------
	logic [NW-1:0]   num_c  [3];
	logic [XW-1:0]   x_c    [3];
	logic [XW-1:0]   recip;
	logic [XW-1:0]   x_s4   [3];
	logic [2*XW-1:0] prod_s4 [3];
	logic            emit_s4, last_s4;
	div_t            div_s4;

	always_comb begin
		case (div_s3)
			DIV_3:   recip = RECIP3;
			DIV_9:   recip = RECIP9;
			default: recip = '0;
		endcase
	end

	// (2*sum + n) / 2n, with the power of two taken off by the shift
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			num_c[ch] = {sum_s3[ch], 1'b0} + NW'(n_s3);
			x_c[ch]   = XW'(num_c[ch] >> sh_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s4 <= 1'b0;
		end else if (adv) begin
			emit_s4 <= emit_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int ch = 0; ch < 3; ch++) begin
				x_s4[ch]    <= x_c[ch];
				prod_s4[ch] <= x_c[ch] * recip;
			end
			div_s4  <= div_s3;
			last_s4 <= last_s3;
		end
	end

	// ---------------------------------------------------------------
	// Output stage: quotient correction and output register
	// ---------------------------------------------------------------
	logic [XW-1:0]   q0   [3];
	logic [XW+3:0]   qd   [3];
	logic [XW+3:0]   rem  [3];
	logic [XW-1:0]   quo  [3];
	logic [CB-1:0]   mean [3];
	pix_out_t        blur_q;

	// the reciprocal estimate is low by at most one
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			q0[ch] = prod_s4[ch][2*XW-1:XW];
			case (div_s4)
				DIV_3: begin
					qd[ch]  = {3'b0, q0[ch], 1'b0} + (XW+4)'(q0[ch]);
					rem[ch] = (XW+4)'(x_s4[ch]) - qd[ch];
					quo[ch] = (rem[ch] >= (XW+4)'(3)) ? q0[ch] + XW'(1) : q0[ch];
				end
				DIV_9: begin
					qd[ch]  = {1'b0, q0[ch], 3'b0} + (XW+4)'(q0[ch]);
					rem[ch] = (XW+4)'(x_s4[ch]) - qd[ch];
					quo[ch] = (rem[ch] >= (XW+4)'(9)) ? q0[ch] + XW'(1) : q0[ch];
				end
				default: begin
					qd[ch]  = '0;
					rem[ch] = '0;
					quo[ch] = x_s4[ch];
				end
			endcase
			mean[ch] = quo[ch][CB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blur_valid_q <= 1'b0;
		end else if (adv) begin
			blur_valid_q <= emit_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			blur_q.chan_a_out <= 16'(mean[0]);
			blur_q.chan_b_out <= 16'(mean[1]);
			blur_q.chan_c_out <= 16'(mean[2]);
			blur_q.frame_end  <= last_s4;
		end
	end

	assign blur_valid = blur_valid_q;
	assign blur       = blur_q;

endmodule

`default_nettype wire
